FILE: rtl/core/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// shared types, character codes and helpers of the json string escaper
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

  // longest result run of one input beat
  localparam int unsigned MAX_RES = 13;
  localparam int unsigned RUN_W   = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam logic [7:0] CP_BS  = 8'h08;
  localparam logic [7:0] CP_TAB = 8'h09;
  localparam logic [7:0] CP_LF  = 8'h0a;
  localparam logic [7:0] CP_FF  = 8'h0c;
  localparam logic [7:0] CP_CR  = 8'h0d;

  localparam logic [20:0] PLANE1_BASE = 21'h10000;
  localparam logic [15:0] SURR_HI     = 16'hd800;
  localparam logic [15:0] SURR_LO     = 16'hdc00;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_out;
    logic [31:0] nul_count;
    logic [31:0] non_ascii_count;
  } out_beat_t;

  // lower-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    if (d < 4'd10) begin
      hex_char = 8'h30 + {4'b0, d};
    end else begin
      hex_char = 8'h57 + {4'b0, d};
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jse_in_if.sv
// ----------------------------------------------------------------------------
// jse_in_if
// valid/ready channel carrying input byte beats
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_in_if
  import jse_pkg::*;
;
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jse_out_if.sv
// ----------------------------------------------------------------------------
// jse_out_if
// valid/ready channel carrying escaped output beats
// ----------------------------------------------------------------------------
`default_nettype none

interface jse_out_if
  import jse_pkg::*;
;
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// streaming json string quoting and escaping of utf-8 bytes
// ----------------------------------------------------------------------------
// the first result beat of an input beat is valid in the cycle after the beat is taken
// an input beat yields 0 to 13 result beats, which the run buffer drains one result
//   beat a cycle on the output port while that port is ready
// an input beat is taken in the same cycle as the last beat of the previous run
// reset: gather state, counters, the escape setting and the run buffer valid clear
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper
  import jse_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire        cfg_wdata_i,
  jse_in_if.sink     in_i,
  jse_out_if.source  out_o
);

  // configuration
  logic esc_q;

  // scalar gather state
  logic [23:0] pend_q, pend_d;
  logic [1:0]  exp_q, exp_d;
  logic [1:0]  held_q, held_d;
  logic [31:0] nul_q, nul_d;
  logic [31:0] non_q, non_d;

  // run buffer: the result run of one beat, drained a byte a cycle while the output is ready
  logic [7:0]       run_q [MAX_RES];
  logic [7:0]       run_d [MAX_RES];
  logic [RUN_W-1:0] len_q, len_d;
  logic [RUN_W-1:0] idx_q;
  logic             vld_q;
  logic [31:0]      run_nul_q, run_non_q;

  // decode intermediates
  logic [7:0]       byte_in;
  logic             first_in, last_in, empty_in;
  logic [1:0]       held_e, exp_e;
  logic [23:0]      pend_e;
  logic [1:0]       need;
  logic             emit;
  logic [31:0]      packed_w;
  logic [7:0]       raw0, raw1, raw2, raw3;
  logic [20:0]      pt;
  logic [20:0]      sup;
  logic [15:0]      unit_a, unit_b;
  logic [7:0]       scal [MAX_RES];
  logic [RUN_W-1:0] slen;
  logic [RUN_W:0]   tot;
  logic [RUN_W:0]   pos;
  logic             bump_nul, bump_non;

  logic run_end;
  logic in_acc;
  logic out_acc;

  assign byte_in  = in_i.data.in_byte;
  assign first_in = in_i.data.first_byte;
  assign last_in  = in_i.data.last_byte;
  assign empty_in = in_i.data.empty_string;

  assign run_end     = (idx_q == len_q - RUN_W'(1));
  assign out_acc     = out_o.valid && out_o.ready;
  // a new beat enters when the buffer is empty or while the last byte of the current run leaves
  assign in_i.ready  = !vld_q || (out_o.ready && run_end);
  assign in_acc      = in_i.valid && in_i.ready;

  always_comb begin
    // a first byte drops any partial scalar
    held_e = first_in ? 2'd0 : held_q;
    exp_e  = first_in ? 2'd0 : exp_q;
    pend_e = first_in ? 24'd0 : pend_q;

    if (byte_in < 8'h80) begin
      need = 2'd0;
    end else if (byte_in < 8'he0) begin
      need = 2'd1;
    end else if (byte_in < 8'hf0) begin
      need = 2'd2;
    end else begin
      need = 2'd3;
    end

    emit = !empty_in &&
           (((held_e == 2'd0) && (need == 2'd0)) ||
            ((held_e != 2'd0) && (held_e >= exp_e)));

    // left-align the held bytes and the new byte, oldest on top
    case (held_e)
      2'd0:    packed_w = {byte_in, 24'd0};
      2'd1:    packed_w = {pend_e[7:0], byte_in, 16'd0};
      2'd2:    packed_w = {pend_e[15:0], byte_in, 8'd0};
      default: packed_w = {pend_e, byte_in};
    endcase
    raw0 = packed_w[31:24];
    raw1 = packed_w[23:16];
    raw2 = packed_w[15:8];
    raw3 = packed_w[7:0];

    case (held_e)
      2'd0:    pt = {13'd0, raw0};
      2'd1:    pt = {10'd0, raw0[4:0], raw1[5:0]};
      2'd2:    pt = {5'd0, raw0[3:0], raw1[5:0], raw2[5:0]};
      default: pt = {raw0[2:0], raw1[5:0], raw2[5:0], raw3[5:0]};
    endcase

    sup    = pt - PLANE1_BASE;
    unit_a = pt[15:0];
    unit_b = SURR_LO + {6'd0, sup[9:0]};
    if (pt > 21'h00ffff) begin
      unit_a = SURR_HI + {5'd0, sup[20:10]};
    end

    for (int i = 0; i < MAX_RES; i++) begin
      scal[i] = 8'd0;
    end
    slen     = '0;
    bump_nul = 1'b0;
    bump_non = 1'b0;

    // two-character escapes
    scal[0] = CH_BSL;
    if (pt == {13'd0, CH_QUOTE}) begin
      scal[1] = CH_QUOTE;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CH_BSL}) begin
      scal[1] = CH_BSL;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CP_BS}) begin
      scal[1] = CH_B;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CP_FF}) begin
      scal[1] = CH_F;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CP_LF}) begin
      scal[1] = CH_N;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CP_CR}) begin
      scal[1] = CH_R;
      slen    = RUN_W'(2);
    end else if (pt == {13'd0, CP_TAB}) begin
      scal[1] = CH_T;
      slen    = RUN_W'(2);
    end else if ((pt < 21'h20) || (esc_q && (pt > 21'h7f))) begin
      // \uXXXX, plus the low surrogate above the basic plane
      scal[1] = CH_U;
      scal[2] = hex_char(unit_a[15:12]);
      scal[3] = hex_char(unit_a[11:8]);
      scal[4] = hex_char(unit_a[7:4]);
      scal[5] = hex_char(unit_a[3:0]);
      scal[6] = CH_BSL;
      scal[7] = CH_U;
      scal[8] = hex_char(unit_b[15:12]);
      scal[9] = hex_char(unit_b[11:8]);
      scal[10] = hex_char(unit_b[7:4]);
      scal[11] = hex_char(unit_b[3:0]);
      if (pt < 21'h20) begin
        slen     = RUN_W'(6);
        bump_nul = (pt == 21'd0);
      end else begin
        slen     = (pt > 21'h00ffff) ? RUN_W'(12) : RUN_W'(6);
        bump_non = 1'b1;
      end
    end else begin
      // raw bytes pass through
      scal[0] = raw0;
      scal[1] = raw1;
      scal[2] = raw2;
      scal[3] = raw3;
      slen    = RUN_W'({2'b0, held_e}) + RUN_W'(1);
    end

    if (!emit) begin
      slen     = '0;
      bump_nul = 1'b0;
      bump_non = 1'b0;
    end

    // assemble quotes and scalar text, capped at the run length
    if (empty_in) begin
      for (int i = 0; i < MAX_RES; i++) begin
        run_d[i] = (i < 2) ? CH_QUOTE : 8'd0;
      end
      tot = (RUN_W + 1)'(2);
    end else begin
      for (int i = 0; i < MAX_RES; i++) begin
        pos = (RUN_W + 1)'(i) - {{RUN_W{1'b0}}, first_in};
        if (first_in && (i == 0)) begin
          run_d[i] = CH_QUOTE;
        end else if (pos < {1'b0, slen}) begin
          run_d[i] = scal[pos[RUN_W-1:0]];
        end else if (last_in && (pos == {1'b0, slen})) begin
          run_d[i] = CH_QUOTE;
        end else begin
          run_d[i] = 8'd0;
        end
      end
      tot = {1'b0, slen} + {{RUN_W{1'b0}}, first_in} + {{RUN_W{1'b0}}, last_in};
    end
    pos  = '0;
    len_d = (tot > (RUN_W + 1)'(MAX_RES)) ? RUN_W'(MAX_RES) : tot[RUN_W-1:0];

    // next gather state
    pend_d = pend_e;
    exp_d  = exp_e;
    held_d = held_e;
    if (empty_in || emit) begin
      pend_d = '0;
      exp_d  = '0;
      held_d = '0;
    end else if (held_e == 2'd0) begin
      pend_d = {16'd0, byte_in};
      exp_d  = need;
      held_d = 2'd1;
    end else begin
      pend_d = {pend_e[15:0], byte_in};
      held_d = held_e + 2'd1;
    end
    if (!empty_in && last_in) begin
      pend_d = '0;
      exp_d  = '0;
      held_d = '0;
    end

    // saturating tallies
    nul_d = nul_q;
    non_d = non_q;
    if (bump_nul && (nul_q != 32'hffff_ffff)) begin
      nul_d = nul_q + 32'd1;
    end
    if (bump_non && (non_q != 32'hffff_ffff)) begin
      non_d = non_q + 32'd1;
    end
  end

  // config register; write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else if (cfg_we_i) begin
      esc_q <= cfg_wdata_i;
    end
  end

  // gather state and tallies move on every taken input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      exp_q  <= '0;
      held_q <= '0;
      nul_q  <= '0;
      non_q  <= '0;
    end else if (in_acc) begin
      pend_q <= pend_d;
      exp_q  <= exp_d;
      held_q <= held_d;
      nul_q  <= nul_d;
      non_q  <= non_d;
    end
  end

  // run buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
      len_q <= '0;
    end else if (in_acc) begin
      // a beat with no result leaves the buffer empty
      vld_q <= (len_d != '0);
      idx_q <= '0;
      len_q <= len_d;
    end else if (out_acc) begin
      if (run_end) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + RUN_W'(1);
      end
    end
  end

  // run buffer payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_q     <= run_d;
      run_nul_q <= nul_d;
      run_non_q <= non_d;
    end
  end

  assign out_o.valid                = vld_q;
  assign out_o.data.out_byte        = run_q[idx_q];
  assign out_o.data.last_out        = run_end;
  assign out_o.data.nul_count       = run_nul_q;
  assign out_o.data.non_ascii_count = run_non_q;

`ifndef SYNTHESIS
  // the byte pointer never leaves the loaded run
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> ((len_q != '0) && (idx_q < len_q)))
    else $error("run pointer outside run");

  // a new beat never overwrites a run that still has bytes to deliver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && vld_q) |-> (out_acc && run_end))
    else $error("run overwritten");

  // gather never holds more bytes than the lead asked for
  a_gather_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q <= exp_q) && ((held_q == 2'd0) || (exp_q != 2'd0)))
    else $error("gather state inconsistent");

  // tallies never go down
  a_tally_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((nul_q >= $past(nul_q)) && (non_q >= $past(non_q))))
    else $error("tally decreased");
`endif

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the json string escaper: byte beats in, quoted
// and escaped text beats out, scored against an in-bench model of the
// gather, escape and counting behavior under random handshake pressure
// ----------------------------------------------------------------------------

module tb
  import jse_pkg::*;
;

  // utf-8 lead byte boundaries as the block classifies them
  localparam logic [7:0] LEAD2 = 8'h80;
  localparam logic [7:0] LEAD3 = 8'he0;
  localparam logic [7:0] LEAD4 = 8'hf0;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  jse_in_if  in_bus ();
  jse_out_if out_bus ();

  json_string_escaper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // byte beats waiting to be offered, and escaped text still owed by the dut
  in_beat_t    raw_bytes_q[$];
  out_beat_t   json_text_q[$];
  int unsigned beats_owed;
  int unsigned phase_beats;
  int unsigned mismatches;

  // handshake pressure, in percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          offering;

  // mirror of the block: escape setting, scalar being gathered, tallies
  bit          escape_on;
  logic [23:0] pend;
  logic [1:0]  need_cnt;
  logic [1:0]  held_cnt;
  logic [31:0] nul_seen;
  logic [31:0] wide_seen;
  logic [7:0]  glyph[0:3];
  logic [7:0]  run_q[$];

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one line per mismatch, quiet after the first fifty
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 50) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // model of the escaper
  // ---------------------------------------------------------------------------

  // one text byte of the current run, capped at the longest legal run
  function automatic void text_push(logic [7:0] b);
    if (run_q.size() < MAX_RES) begin
      run_q.push_back(b);
    end
  endfunction

  function automatic logic [7:0] nibble_ascii(logic [3:0] d);
    return (d < 4'd10) ? 8'h30 + {4'b0, d} : 8'h57 + {4'b0, d};
  endfunction

  // backslash, u, four lower-case hex digits
  function automatic void push_u_escape(logic [15:0] unit);
    text_push(CH_BSL);
    text_push(CH_U);
    text_push(nibble_ascii(unit[15:12]));
    text_push(nibble_ascii(unit[11:8]));
    text_push(nibble_ascii(unit[7:4]));
    text_push(nibble_ascii(unit[3:0]));
  endfunction

  function automatic void drop_partial();
    pend     = '0;
    need_cnt = '0;
    held_cnt = '0;
  endfunction

  // text of one complete scalar held in glyph[0 .. cnt-1]
  function automatic void escape_scalar(int unsigned cnt);
    logic [20:0] cp;
    logic [31:0] off;
    logic [7:0]  mark;
    int unsigned i;
    case (cnt)
      1: cp = {13'd0, glyph[0]};
      2: cp = {10'd0, glyph[0][4:0], glyph[1][5:0]};
      3: cp = {5'd0, glyph[0][3:0], glyph[1][5:0], glyph[2][5:0]};
      default: cp = {glyph[0][2:0], glyph[1][5:0], glyph[2][5:0], glyph[3][5:0]};
    endcase
    // two-character escapes, overlong forms included
    case (cp)
      {13'd0, CH_QUOTE}: mark = CH_QUOTE;
      {13'd0, CH_BSL}:   mark = CH_BSL;
      {13'd0, CP_BS}:    mark = CH_B;
      {13'd0, CP_FF}:    mark = CH_F;
      {13'd0, CP_LF}:    mark = CH_N;
      {13'd0, CP_CR}:    mark = CH_R;
      {13'd0, CP_TAB}:   mark = CH_T;
      default:           mark = 8'h00;
    endcase
    if (mark != 8'h00) begin
      text_push(CH_BSL);
      text_push(mark);
    end else if (cp < 21'h20) begin
      // remaining controls, nul counted
      push_u_escape(cp[15:0]);
      if (cp == 21'd0 && nul_seen != 32'hffff_ffff) begin
        nul_seen++;
      end
    end else if (escape_on && cp > 21'h7f) begin
      if (cp <= 21'hffff) begin
        push_u_escape(cp[15:0]);
      end else begin
        // surrogate pair, applied as is past the top of unicode
        off = {11'd0, cp} - {11'd0, PLANE1_BASE};
        push_u_escape(SURR_HI + off[25:10]);
        push_u_escape(SURR_LO + {6'd0, off[9:0]});
      end
      if (wide_seen != 32'hffff_ffff) begin
        wide_seen++;
      end
    end else begin
      // plain ascii or unescaped multi-byte: original bytes
      for (i = 0; i < cnt; i++) begin
        text_push(glyph[i]);
      end
    end
  endfunction

  // expected text beats for one accepted byte beat
  function automatic void quote_and_escape(in_beat_t b);
    out_beat_t   t;
    int unsigned h;
    int unsigned i;
    run_q.delete();
    if (b.empty_string) begin
      drop_partial();
      text_push(CH_QUOTE);
      text_push(CH_QUOTE);
    end else begin
      if (b.first_byte) begin
        drop_partial();
        text_push(CH_QUOTE);
      end
      if (held_cnt == 2'd0) begin
        if (b.in_byte < LEAD2) begin
          glyph[0] = b.in_byte;
          escape_scalar(1);
        end else begin
          // any byte from 80 up opens a scalar
          pend     = {16'd0, b.in_byte};
          need_cnt = (b.in_byte < LEAD3) ? 2'd1 : (b.in_byte < LEAD4) ? 2'd2 : 2'd3;
          held_cnt = 2'd1;
        end
      end else if (held_cnt >= need_cnt) begin
        h = 32'(held_cnt);
        for (i = 0; i < h; i++) begin
          glyph[i] = pend[8 * (h - 1 - i) +: 8];
        end
        glyph[h] = b.in_byte;
        escape_scalar(h + 1);
        drop_partial();
      end else begin
        pend     = {pend[15:0], b.in_byte};
        held_cnt = held_cnt + 2'd1;
      end
      // an unfinished scalar is lost at the closing quote
      if (b.last_byte) begin
        drop_partial();
        text_push(CH_QUOTE);
      end
    end
    for (i = 0; i < run_q.size(); i++) begin
      t.out_byte        = run_q[i];
      t.last_out        = (i == run_q.size() - 1);
      t.nul_count       = nul_seen;
      t.non_ascii_count = wide_seen;
      json_text_q.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued byte beats, holds each until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (offering && in_bus.ready) begin
        quote_and_escape(in_bus.data);
        beats_owed--;
        offering = 1'b0;
      end
      if (!offering && raw_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_bus.data <= raw_bytes_q.pop_front();
        offering = 1'b1;
      end
      // one update of valid per edge, so back-to-back beats keep it high
      in_bus.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: scores each text beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : take_text
    out_beat_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (json_text_q.size() == 0) begin
          report_mismatch("beat with nothing owed", {24'd0, out_bus.data.out_byte}, '0);
        end else begin
          want = json_text_q.pop_front();
          if (out_bus.data.out_byte !== want.out_byte) begin
            report_mismatch("out_byte", {24'd0, out_bus.data.out_byte}, {24'd0, want.out_byte});
          end
          if (out_bus.data.last_out !== want.last_out) begin
            report_mismatch("last_out", {31'd0, out_bus.data.last_out}, {31'd0, want.last_out});
          end
          if (out_bus.data.nul_count !== want.nul_count) begin
            report_mismatch("nul_count", out_bus.data.nul_count, want.nul_count);
          end
          if (out_bus.data.non_ascii_count !== want.non_ascii_count) begin
            report_mismatch("non_ascii_count", out_bus.data.non_ascii_count,
                            want.non_ascii_count);
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic [7:0] v, bit f, bit l, bit e);
    in_beat_t b;
    b.in_byte      = v;
    b.first_byte   = f;
    b.last_byte    = l;
    b.empty_string = e;
    raw_bytes_q.push_back(b);
    beats_owed++;
    phase_beats++;
  endtask

  // one string of random scalars; mangled strings get cut short, restarted
  // mid-way or left without a closing byte
  task automatic push_string(bit mangle);
    logic [7:0]  seq[$];
    logic [7:0]  lead_b;
    int unsigned n_sc;
    int unsigned k;
    int unsigned j;
    int unsigned tail;
    int unsigned how;
    int unsigned split;
    bit          nul_form;
    n_sc = $urandom_range(1, 6);
    for (k = 0; k < n_sc; k++) begin
      tail     = 0;
      nul_form = 1'b0;
      case ($urandom_range(9))
        0, 1, 2: lead_b = 8'($urandom_range(8'h20, 8'h7e));
        3: begin
          case ($urandom_range(8))
            0: lead_b = CH_QUOTE;
            1: lead_b = CH_BSL;
            2: lead_b = CP_BS;
            3: lead_b = CP_FF;
            4: lead_b = CP_LF;
            5: lead_b = CP_CR;
            6: lead_b = CP_TAB;
            7: lead_b = 8'h7f;
            default: lead_b = 8'($urandom_range(8'h1f));
          endcase
        end
        4: begin
          // modified utf-8 nul
          lead_b   = 8'hc0;
          tail     = 1;
          nul_form = 1'b1;
        end
        // two-byte leads from c0 up, so overlong escapes show up too
        5, 6: begin
          lead_b = 8'($urandom_range(8'hc0, 8'hdf));
          tail   = 1;
        end
        7, 8: begin
          lead_b = 8'($urandom_range(8'he0, 8'hef));
          tail   = 2;
        end
        default: begin
          // mostly in range, now and then past 10ffff
          lead_b = 8'(($urandom_range(3) == 0) ? $urandom_range(8'hf0, 8'hff)
                                               : $urandom_range(8'hf0, 8'hf4));
          tail   = 3;
        end
      endcase
      seq.push_back(lead_b);
      for (j = 0; j < tail; j++) begin
        if (nul_form) begin
          seq.push_back(8'h80);
        end else if ($urandom_range(7) == 0) begin
          seq.push_back(8'($urandom_range(255)));
        end else begin
          seq.push_back({2'b10, 6'($urandom_range(63))});
        end
      end
    end
    how = mangle ? $urandom_range(2) : 3;
    if (how == 0 && seq.size() > 1) begin
      void'(seq.pop_back());
    end
    split = (how == 1 && seq.size() > 1) ? $urandom_range(1, seq.size() - 1) : 0;
    for (j = 0; j < seq.size(); j++) begin
      push_beat(seq[j], (j == 0) || (split != 0 && j == split),
                (how != 2) && (j == seq.size() - 1), 1'b0);
    end
  endtask

  // wait out every owed beat and all expected text, then idle for gather-only beats
  task automatic settle();
    while (beats_owed != 0 || json_text_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_escape(bit v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    escape_on = v;
    cfg_we_i  <= 1'b0;
  endtask

  // idle, reconfigure, then a batch of mostly well-formed strings
  task automatic run_phase(bit esc, int unsigned send_pct, int unsigned stall_pct,
                           int unsigned n_beats);
    int unsigned pick;
    int unsigned j;
    settle();
    set_escape(esc);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phase_beats    = 0;
    while (phase_beats < n_beats) begin
      pick = $urandom_range(99);
      if (pick < 76) begin
        push_string(1'b0);
      end else if (pick < 88) begin
        push_string(1'b1);
      end else if (pick < 94) begin
        // empty string, other fields random
        push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'b1);
      end else begin
        // loose noise beats
        for (j = $urandom_range(1, 3); j > 0; j--) begin
          push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.data    = '0;
    out_bus.ready  = 1'b0;
    offering       = 1'b0;
    beats_owed     = 0;
    phase_beats    = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    escape_on      = 1'b0;
    nul_seen       = '0;
    wide_seen      = '0;
    drop_partial();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed strings with escaping on
    set_escape(1'b1);
    push_beat(8'hff, 1'b1, 1'b1, 1'b1);       // empty string, junk byte
    push_beat(CH_QUOTE, 1'b1, 1'b0, 1'b0);    // opening quote plus escaped quote
    push_beat(CH_BSL, 1'b0, 1'b0, 1'b0);
    push_beat(CP_BS, 1'b0, 1'b0, 1'b0);
    push_beat(CP_FF, 1'b0, 1'b0, 1'b0);
    push_beat(CP_LF, 1'b0, 1'b0, 1'b0);
    push_beat(CP_CR, 1'b0, 1'b0, 1'b0);
    push_beat(CP_TAB, 1'b0, 1'b0, 1'b0);
    push_beat(8'h1f, 1'b0, 1'b0, 1'b0);       // other control, hex form
    push_beat(8'h7f, 1'b0, 1'b0, 1'b0);       // top of ascii, passes
    push_beat(8'hc0, 1'b0, 1'b0, 1'b0);       // c0 80 nul
    push_beat(8'h80, 1'b0, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0, 1'b0);       // stray continuation as a lead
    push_beat(8'h41, 1'b0, 1'b0, 1'b0);
    push_beat(8'he2, 1'b0, 1'b0, 1'b0);       // three-byte scalar
    push_beat(8'h82, 1'b0, 1'b0, 1'b0);
    push_beat(8'hac, 1'b0, 1'b0, 1'b0);
    push_beat(8'hf7, 1'b0, 1'b0, 1'b0);       // beyond 10ffff, longest run
    push_beat(8'hbf, 1'b0, 1'b0, 1'b0);
    push_beat(8'hbf, 1'b0, 1'b0, 1'b0);
    push_beat(8'hbf, 1'b0, 1'b1, 1'b0);
    push_beat(8'hf0, 1'b1, 1'b0, 1'b0);       // restart in the middle of a scalar
    push_beat(8'h9f, 1'b0, 1'b0, 1'b0);
    push_beat(8'he9, 1'b1, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b1, 1'b0);       // scalar cut off by the last byte
    push_beat(8'hff, 1'b1, 1'b1, 1'b0);       // lone lead, first and last at once

    // random phases across both settings and every kind of pressure
    run_phase(1'b0, 0, 0, 50);
    run_phase(1'b1, 58, 0, 50);
    run_phase(1'b0, 0, 58, 50);
    run_phase(1'b1, 9, 9, 50);

    settle();
    repeat (10) @(posedge clk_i);
    if (json_text_q.size() != 0) begin
      report_mismatch("text beats never seen", json_text_q.size(), 0);
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
